/* rtl/core/fixed_point_alu_macros.svh */
//------------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Shared concurrent assertion forms for the ALU RTL.
//------------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// implication checked every cycle outside reset
`define FPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define FPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/fpa_pkg.sv */
//------------------------------------------------------------------------------
// Fixed-point ALU package
// Widths, mode codes and the item record carried along the cell chain.
//------------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;
  localparam int FRACTION_BITS = 8;
  localparam int W = 32;
  localparam int NW = W + FRACTION_BITS;     // divider numerator width
  localparam int NCELL = NW;                 // one quotient bit per cell

  typedef enum logic [3:0] {
    MODE_ADD = 4'd0, MODE_SUB = 4'd1, MODE_MUL = 4'd2, MODE_DIV = 4'd3,
    MODE_MIN = 4'd4, MODE_MAX = 4'd5, MODE_INC = 4'd6, MODE_DEC = 4'd7,
    MODE_TOINT = 4'd8, MODE_FROMINT = 4'd9, MODE_CMP = 4'd10
  } mode_t;

  // word travelling down the chain
  typedef struct packed {
    logic          valid;
    logic [3:0]    mode;
    logic          neg;        // result sign for mul/div
    logic [NW-1:0] num;        // numerator bits, shifted out MSB first
    logic [W:0]    rem;        // partial remainder
    logic [NW-1:0] quo;        // quotient bits so far
    logic [W-1:0]  den;        // |b|
    logic [W-1:0]  res;        // result for non-divide modes and divide by zero
    logic [4:0]    flags;      // {dz, ovf, equal, less, greater}
  } cell_t;

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
endpackage
`default_nettype wire

/* rtl/core/fpa_front.sv */
//------------------------------------------------------------------------------
// Fixed-point ALU front stage
// Decodes the operands, computes every non-divide mode and seeds the divider.
//------------------------------------------------------------------------------
`default_nettype none
module fpa_front import fpa_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire logic [3:0]   mode,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output cell_t             q
);
  localparam int PW = 2 * W;
  logic signed [W-1:0] sa, sb;
  logic [W-1:0] ma, mb;
  logic [PW-1:0] prod;
  logic [PW-1:0] pr;
  logic signed [W+1:0] sum;
  logic signed [W+FRACTION_BITS:0] fi;
  logic [W-1:0] res;
  logic ovf, neg;
  cell_t d;

  // saturate a wide signed value to W bits, overflow in the top bit
  function automatic logic [W:0] sat(input logic signed [PW:0] v);
    if (v > $signed({{(PW-W+1){1'b0}}, WMAX})) sat = {1'b1, WMAX};
    else if (v < $signed({{(PW-W+1){1'b1}}, WMIN})) sat = {1'b1, WMIN};
    else sat = {1'b0, v[W-1:0]};
  endfunction

  always_comb begin
    logic [W:0] s;
    sa = $signed(a);
    sb = $signed(b);
    ma = sa[W-1] ? W'(-a) : a;
    mb = sb[W-1] ? W'(-b) : b;
    neg = sa[W-1] ^ sb[W-1];
    prod = PW'(ma) * PW'(mb);
    pr = (prod + PW'((FRACTION_BITS > 0) ? (64'd1 << (FRACTION_BITS - 1)) : 64'd0))
         >> FRACTION_BITS;
    sum = '0;
    fi = '0;
    s = '0;
    res = '0;
    ovf = 1'b0;
    unique case (mode)
      MODE_ADD: begin sum = (W+2)'(sa) + (W+2)'(sb); s = sat((PW+1)'(sum)); end
      MODE_SUB: begin sum = (W+2)'(sa) - (W+2)'(sb); s = sat((PW+1)'(sum)); end
      MODE_INC: begin sum = (W+2)'(sa) + 1; s = sat((PW+1)'(sum)); end
      MODE_DEC: begin sum = (W+2)'(sa) - 1; s = sat((PW+1)'(sum)); end
      MODE_MUL: begin
        if (pr > PW'(WMAX) + PW'(neg)) s = {1'b1, neg ? WMIN : WMAX};
        else s = {1'b0, neg ? W'(-pr[W-1:0]) : pr[W-1:0]};
      end
      MODE_FROMINT: begin
        fi = (W+FRACTION_BITS+1)'(sa) <<< FRACTION_BITS;
        s = sat((PW+1)'(fi));
      end
      MODE_MIN: s = {1'b0, (sa <= sb) ? a : b};
      MODE_MAX: s = {1'b0, (sa >= sb) ? a : b};
      MODE_TOINT: s = {1'b0, W'(sa >>> FRACTION_BITS)};
      MODE_DIV: begin
        if (b == '0) s = {1'b0, (sa > 0) ? WMAX : ((sa < 0) ? WMIN : '0)};
      end
      default: s = '0;
    endcase
    ovf = s[W];
    res = s[W-1:0];
    d.valid = in_valid;
    d.mode = mode;
    d.neg = neg;
    d.num = {ma, {FRACTION_BITS{1'b0}}};
    d.rem = '0;
    d.quo = '0;
    d.den = mb;
    d.res = res;
    d.flags = {(mode == MODE_DIV) && (b == '0), ovf, sa == sb, sa < sb, sa > sb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.mode <= d.mode; q.neg <= d.neg; q.num <= d.num; q.rem <= d.rem;
      q.quo <= d.quo; q.den <= d.den; q.res <= d.res; q.flags <= d.flags;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/fpa_cell.sv */
//------------------------------------------------------------------------------
// Fixed-point ALU divider cell
// One restoring-division step: develops one quotient bit and passes the word on.
//------------------------------------------------------------------------------
`default_nettype none
module fpa_cell import fpa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  cell_t     d,
  output cell_t     q
);
  cell_t n;
  logic [W:0] sh;
  logic [W+1:0] diff;

  always_comb begin
    n = d;
    sh = {d.rem[W-1:0], d.num[NW-1]};
    diff = {1'b0, sh} - {2'b0, d.den};
    n.num = {d.num[NW-2:0], 1'b0};
    if (!diff[W+1]) begin
      n.rem = diff[W:0];
      n.quo = {d.quo[NW-2:0], 1'b1};
    end else begin
      n.rem = sh;
      n.quo = {d.quo[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= n.valid;
    end
    if (en) begin
      q.mode <= n.mode; q.neg <= n.neg; q.num <= n.num; q.rem <= n.rem;
      q.quo <= n.quo; q.den <= n.den; q.res <= n.res; q.flags <= n.flags;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/fpa_back.sv */
//------------------------------------------------------------------------------
// Fixed-point ALU back stage
// Rounds and saturates the quotient and selects the final result word.
//------------------------------------------------------------------------------
`default_nettype none
module fpa_back import fpa_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  cell_t             d,
  output logic              valid,
  output logic [W-1:0]      res,
  output logic [4:0]        flags
);
  logic [NW:0] qr;
  logic up, big;
  logic [W-1:0] r;
  logic [4:0] f;

  always_comb begin
    // round half away from zero: rem >= den - rem
    up = ({1'b0, d.rem} << 1) >= {2'b0, d.den};
    qr = {1'b0, d.quo} + (NW+1)'(up);
    big = qr > ((NW+1)'(WMAX) + (NW+1)'(d.neg));
    r = d.res;
    f = d.flags;
    if (d.mode == MODE_DIV && !d.flags[4]) begin
      if (big) begin
        r = d.neg ? WMIN : WMAX;
        f[3] = 1'b1;
      end else begin
        r = d.neg ? W'(-qr[W-1:0]) : qr[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= d.valid;
    end
    if (en) begin
      res <= r;
      flags <= f;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/fixed_point_alu.sv */
// Each word passes the registered front stage, the cell chain and the back stage.
// Throughput: one word per cycle while the output word is taken; a chain of
// restoring-division cells, one quotient bit per cell, carries every word, whatever
// its mode. The whole chain stalls together when the output word is not taken.
// Reset: synchronous, active high; clears all valid bits, chain empty.
//------------------------------------------------------------------------------
// Fixed-point ALU top level
// Stream-in operands, stream-out result and flags through a cell chain.
//------------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_alu_macros.svh"
module fixed_point_alu import fpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // mode[3:0], operand_a[35:4], operand_b[67:36]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // result[31:0], greater, less, equal, overflow,
                                      // divide_by_zero
);
  cell_t chain [NCELL+1];
  logic en;
  logic [W-1:0] res;
  logic [4:0] flags;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  fpa_front u_front (
    .clk, .rst, .en, .in_valid(s_tvalid),
    .mode(s_tdata[3:0]), .a(s_tdata[35:4]), .b(s_tdata[67:36]), .q(chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fpa_cell u_cell (.clk, .rst, .en, .d(chain[i]), .q(chain[i+1]));
  end

  fpa_back u_back (
    .clk, .rst, .en, .d(chain[NCELL]), .valid(m_tvalid), .res, .flags
  );

  assign m_tdata = {3'b0, flags, res};

  `FPA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `FPA_ASSERT_IMP(a_cmp_onehot, m_tvalid, $onehot(m_tdata[34:32]))
  `FPA_ASSERT_IMP(a_dz_no_ovf, m_tvalid && m_tdata[36], !m_tdata[35])
endmodule
`default_nettype wire

/* test/fixed_point_alu_test.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Fixed-point ALU testbench
// Streams directed and random operand words through the ALU with random
// idling on both sides and checks every result word against a predictor.
//------------------------------------------------------------------------------
`default_nettype none
module fixed_point_alu_test;
  import fpa_pkg::*;

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] a;
    logic [31:0] b;
  } op_word_t;

  typedef struct packed {
    logic [31:0] result;
    logic        greater;
    logic        less;
    logic        equal;
    logic        overflow;
    logic        dz;
  } res_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  op_word_t  pending_ops[$];
  res_word_t expected_results[$];
  int        src_idle_pct;
  int        dst_idle_pct;
  int        mismatches;
  int        checked;
  int        cycles;

  fixed_point_alu u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  function automatic logic [31:0] sat_word(input longint v, output logic ovf);
    ovf = 1'b0;
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return WMAX;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return WMIN;
    end
    return v[31:0];
  endfunction

  function automatic res_word_t alu_predict(input op_word_t op);
    res_word_t   r;
    longint      a;
    longint      b;
    longint      q;
    longint      n;
    longint      rem;
    logic [63:0] p;
    logic        neg;
    logic        ovf;
    a = longint'(signed'(op.a));
    b = longint'(signed'(op.b));
    ovf = 1'b0;
    r = '0;
    neg = (a < 0) != (b < 0);
    case (op.mode)
      MODE_ADD: r.result = sat_word(a + b, ovf);
      MODE_SUB: r.result = sat_word(a - b, ovf);
      MODE_MUL: begin
        p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
        p = (p + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        q = longint'(p);
        r.result = sat_word(neg ? -q : q, ovf);
      end
      MODE_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
          r.result = a > 0 ? WMAX : (a < 0 ? WMIN : '0);
        end else begin
          n = (a < 0 ? -a : a) << FRACTION_BITS;
          if (b < 0) b = -b;
          q = n / b;
          rem = n % b;
          if (rem >= b - rem) q++;
          r.result = sat_word(neg ? -q : q, ovf);
          b = longint'(signed'(op.b));
        end
      end
      MODE_MIN: r.result = a <= b ? op.a : op.b;
      MODE_MAX: r.result = a >= b ? op.a : op.b;
      MODE_INC: r.result = sat_word(a + 1, ovf);
      MODE_DEC: r.result = sat_word(a - 1, ovf);
      MODE_TOINT: r.result = 32'(a >>> FRACTION_BITS);
      MODE_FROMINT: r.result = sat_word(a * (longint'(1) << FRACTION_BITS), ovf);
      default: r.result = '0;
    endcase
    r.overflow = ovf;
    r.greater = a > b;
    r.less = a < b;
    r.equal = a == b;
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? WMAX - $urandom_range(0, 3) : WMIN + $urandom_range(0, 3);
      1: return 32'($signed($urandom_range(0, 2047)) - 1024);
      2: return 32'($signed($urandom_range(0, 32'hFFFF)) - 32768);
      3: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        s_tdata <= {4'b0, pending_ops[0].b, pending_ops[0].a, pending_ops[0].mode};
        expected_results.push_back(alu_predict(pending_ops.pop_front()));
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_word_t got;
    res_word_t want;
    got = {m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[34], m_tdata[35], m_tdata[36]};
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(0, 99) >= dst_idle_pct;
      if (m_tvalid && m_tready) begin
        checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected res=%h g%b l%b e%b ovf%b dz%b, ",
                       want.result, want.greater, want.less, want.equal, want.overflow, want.dz,
                       "got res=%h g%b l%b e%b ovf%b dz%b",
                       got.result, got.greater, got.less, got.equal, got.overflow, got.dz);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 200000) begin
      $display("fixed_point_alu_test failed");
      $finish;
    end
  end

  task automatic add_op(input logic [3:0] m, input logic [31:0] a, input logic [31:0] b);
    op_word_t op;
    op.mode = m;
    op.a = a;
    op.b = b;
    pending_ops.push_back(op);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || expected_results.size() > 0 || s_tvalid)
      @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    src_idle_pct = 20;
    dst_idle_pct = 58;
    mismatches = 0;
    checked = 0;
    cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, all modes, saturation, zero divisor, rounding ties
    for (int m = 0; m < 16; m++) add_op(m[3:0], WMAX, WMIN);
    add_op(MODE_DIV, 32'd5, 32'd0);
    add_op(MODE_DIV, WMIN, 32'd0);
    add_op(MODE_DIV, 32'd0, 32'd0);
    add_op(MODE_MUL, 32'd1, 32'd128);
    add_op(MODE_MUL, -32'sd1, 32'd128);
    add_op(MODE_DIV, 32'd1, 32'd512);
    add_op(MODE_DIV, WMIN, -32'sd1);
    add_op(MODE_TOINT, -32'sd1, 32'd0);
    add_op(MODE_INC, WMAX, WMAX);

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = phase == 0 ? 20 : (phase == 1 ? 58 : 0);
      dst_idle_pct = phase == 0 ? 58 : (phase == 1 ? 20 : 0);
      for (int i = 0; i < 483; i++) begin
        add_op($urandom_range(0, 11) == 0 ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10)),
               rand_operand(), $urandom_range(0, 15) == 0 ? 32'd0 : rand_operand());
      end
      wait_drained();
    end
    repeat (100) @(posedge clk);

    $display("ran all eleven modes plus unused codes, %0d result words checked", checked);
    $display("covered saturation, zero divisors, rounding ties and three idling phases");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("fixed_point_alu_test passed");
    end else begin
      $display("fixed_point_alu_test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* fixed_point_alu.f */
+incdir+rtl/core
rtl/core/fpa_pkg.sv
rtl/core/fpa_front.sv
rtl/core/fpa_cell.sv
rtl/core/fpa_back.sv
rtl/core/fixed_point_alu.sv
test/fixed_point_alu_test.sv
